@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/icp_pkg.sv @@
// ----------------------------------------------------------------------------
// icp_pkg
// Shared types and constants of the IPv4 CIDR text parser.
// ----------------------------------------------------------------------------
package icp_pkg;

  // Character classes sent from the front to the back
  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_DOT,
    TK_SLASH,
    TK_TERM,
    TK_OTHER
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [3:0]  digit;
  } token_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ADDR = 2'd1,
    ST_BAD_LEN  = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] address;
    logic [5:0]  prefix_length;
  } result_t;

  // Token queue between front and back
  localparam int TOK_DEPTH = 4;
  localparam int TOK_AW    = $clog2(TOK_DEPTH);

  // Parsing constants
  localparam logic [11:0] OCTET_MAX   = 12'd255;
  localparam logic [5:0]  LENGTH_MAX  = 6'd32;
  localparam logic [9:0]  LENGTH_SAT  = 10'd63;
  localparam logic [1:0]  LAST_OCTET  = 2'd3;
  localparam logic [7:0]  CHAR_ZERO   = 8'h30;
  localparam logic [7:0]  CHAR_NINE   = 8'h39;
  localparam logic [7:0]  CHAR_DOT    = 8'h2E;
  localparam logic [7:0]  CHAR_SLASH  = 8'h2F;
  localparam logic [7:0]  CHAR_NUL    = 8'h00;

endpackage

@@ rtl/core/icp_front.sv @@
// ----------------------------------------------------------------------------
// icp_front
// Classifies each incoming character into a parser token.
// ----------------------------------------------------------------------------
module icp_front import icp_pkg::*; (
  input  logic [7:0] text_char,
  input  logic       is_terminator,
  output token_t     tok
);

  logic is_digit;

  assign is_digit = (text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE);

  // Terminator wins; a zero byte also ends the text
  always_comb begin
    tok.digit = 4'(text_char - CHAR_ZERO);
    if (is_terminator || (text_char == CHAR_NUL)) begin
      tok.kind = TK_TERM;
    end else if (is_digit) begin
      tok.kind = TK_DIGIT;
    end else if (text_char == CHAR_DOT) begin
      tok.kind = TK_DOT;
    end else if (text_char == CHAR_SLASH) begin
      tok.kind = TK_SLASH;
    end else begin
      tok.kind = TK_OTHER;
    end
  end

endmodule

@@ rtl/core/icp_tok_fifo.sv @@
// ----------------------------------------------------------------------------
// icp_tok_fifo
// Short token queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module icp_tok_fifo import icp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr,
  input  token_t wr_tok,
  output logic   full,
  input  logic   rd,
  output token_t rd_tok,
  output logic   empty
);

  token_t              mem_r [TOK_DEPTH];
  logic [TOK_AW-1:0]   wptr_r, wptr_nxt;
  logic [TOK_AW-1:0]   rptr_r, rptr_nxt;
  logic [TOK_AW:0]     cnt_r, cnt_nxt;
  logic                do_wr, do_rd;

  assign full   = (cnt_r == (TOK_AW+1)'(TOK_DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_tok = mem_r[rptr_r];
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;

  // Pointer and count update
  always_comb begin
    wptr_nxt = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_rd ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (TOK_AW+1)'(do_wr) - (TOK_AW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_tok;
    end
  end

endmodule

@@ rtl/core/icp_back.sv @@
// ----------------------------------------------------------------------------
// icp_back
// Parser state machine and two-entry result buffer.
// ----------------------------------------------------------------------------
module icp_back import icp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  token_t  tok,
  input  logic    tok_empty,
  output logic    tok_rd,
  output result_t res,
  output logic    res_empty,
  input  logic    res_pop
);

  typedef enum logic [2:0] {
    PH_ADDR_START,
    PH_ADDR_DIGITS,
    PH_LEN_START,
    PH_LEN_DIGITS,
    PH_LEN_REST
  } phase_t;

  phase_t       phase_r, phase_nxt;
  logic [1:0]   oct_idx_r, oct_idx_nxt;
  logic [7:0]   oct_val_r, oct_val_nxt;
  logic [31:0]  addr_r, addr_nxt;
  logic [5:0]   len_r, len_nxt;
  logic         slash_r, slash_nxt;
  logic         aerr_r, aerr_nxt;
  logic         lerr_r, lerr_nxt;

  result_t      buf_r [2];
  logic         bwptr_r, brptr_r;
  logic [1:0]   bcnt_r;
  logic         buf_full, do_pop, do_push;

  logic [11:0]  oct_acc;
  logic [9:0]   len_acc;
  logic [1:0]   byte_sel;
  logic         term_aerr, term_lerr;
  logic [5:0]   term_len;
  result_t      new_res;

  assign buf_full  = (bcnt_r == 2'd2);
  assign res_empty = (bcnt_r == 2'd0);
  assign res       = buf_r[brptr_r];
  assign do_pop    = res_pop && !res_empty;

  // Terminators wait for buffer room; other tokens always go
  assign tok_rd  = !tok_empty && ((tok.kind != TK_TERM) || !buf_full || do_pop);
  assign do_push = tok_rd && (tok.kind == TK_TERM);

  // Digit accumulation
  assign oct_acc  = 12'(oct_val_r) * 12'd10 + 12'(tok.digit);
  assign len_acc  = 10'(len_r) * 10'd10 + 10'(tok.digit);
  assign byte_sel = LAST_OCTET - oct_idx_r;

  // Result on terminator
  always_comb begin
    term_aerr = aerr_r || (phase_r == PH_ADDR_START);
    term_len  = slash_r ? len_r : LENGTH_MAX;
    term_lerr = lerr_r || (phase_r == PH_LEN_START) || (term_len > LENGTH_MAX);
    if (term_lerr) begin
      new_res.status = ST_BAD_LEN;
    end else if (term_aerr) begin
      new_res.status = ST_BAD_ADDR;
    end else begin
      new_res.status = ST_OK;
    end
    new_res.address       = (new_res.status == ST_OK) ? addr_r : '0;
    new_res.prefix_length = (new_res.status == ST_OK) ? term_len : '0;
  end

  // Next parser state
  always_comb begin
    phase_nxt   = phase_r;
    oct_idx_nxt = oct_idx_r;
    oct_val_nxt = oct_val_r;
    addr_nxt    = addr_r;
    len_nxt     = len_r;
    slash_nxt   = slash_r;
    aerr_nxt    = aerr_r;
    lerr_nxt    = lerr_r;
    if (tok.kind == TK_TERM) begin
      // rearm for the next text
      phase_nxt   = PH_ADDR_START;
      oct_idx_nxt = '0;
      oct_val_nxt = '0;
      addr_nxt    = '0;
      len_nxt     = '0;
      slash_nxt   = 1'b0;
      aerr_nxt    = 1'b0;
      lerr_nxt    = 1'b0;
    end else begin
      unique case (phase_r)
        PH_ADDR_START, PH_ADDR_DIGITS: begin
          if (tok.kind == TK_SLASH) begin
            if (phase_r == PH_ADDR_START) begin
              aerr_nxt = 1'b1;
            end
            slash_nxt = 1'b1;
            phase_nxt = PH_LEN_START;
          end else if (!aerr_r) begin
            if (tok.kind == TK_DIGIT) begin
              if (oct_acc > OCTET_MAX) begin
                aerr_nxt = 1'b1;
              end else begin
                oct_val_nxt                      = oct_acc[7:0];
                addr_nxt[{byte_sel, 3'b000} +: 8] = oct_acc[7:0];
                phase_nxt                        = PH_ADDR_DIGITS;
              end
            end else if ((phase_r == PH_ADDR_DIGITS) && (tok.kind == TK_DOT) &&
                         (oct_idx_r != LAST_OCTET)) begin
              oct_idx_nxt = oct_idx_r + 2'd1;
              oct_val_nxt = '0;
              phase_nxt   = PH_ADDR_START;
            end else begin
              aerr_nxt = 1'b1;
            end
          end
        end
        PH_LEN_START: begin
          if (tok.kind == TK_DIGIT) begin
            len_nxt   = 6'(tok.digit);
            phase_nxt = PH_LEN_DIGITS;
          end else begin
            lerr_nxt  = 1'b1;
            phase_nxt = PH_LEN_REST;
          end
        end
        PH_LEN_DIGITS: begin
          if (tok.kind == TK_DIGIT) begin
            len_nxt = (len_acc > LENGTH_SAT) ? 6'(LENGTH_SAT) : len_acc[5:0];
          end else begin
            phase_nxt = PH_LEN_REST;
          end
        end
        default: begin
          // trailing text after the length is ignored
        end
      endcase
    end
  end

  // State and result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_ADDR_START;
      oct_idx_r <= '0;
      oct_val_r <= '0;
      addr_r    <= '0;
      len_r     <= '0;
      slash_r   <= 1'b0;
      aerr_r    <= 1'b0;
      lerr_r    <= 1'b0;
      bwptr_r   <= 1'b0;
      brptr_r   <= 1'b0;
      bcnt_r    <= '0;
    end else begin
      if (tok_rd) begin
        phase_r   <= phase_nxt;
        oct_idx_r <= oct_idx_nxt;
        oct_val_r <= oct_val_nxt;
        addr_r    <= addr_nxt;
        len_r     <= len_nxt;
        slash_r   <= slash_nxt;
        aerr_r    <= aerr_nxt;
        lerr_r    <= lerr_nxt;
      end
      if (do_push) begin
        buf_r[bwptr_r] <= new_res;
        bwptr_r        <= ~bwptr_r;
      end
      if (do_pop) begin
        brptr_r <= ~brptr_r;
      end
      bcnt_r <= bcnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ rtl/core/ipv4_cidr_text_parser_core.sv @@
// A terminator request shows its result after the token queue write, then the parser
// step into the result buffer.
// Throughput: one character per cycle, limited by the single parser step; a
// terminator waits in the token queue while both result slots are full.
// Reset (rst_n low, synchronous) empties both queues and rearms the parser.
// ----------------------------------------------------------------------------
// ipv4_cidr_text_parser_core
// Dotted decimal IPv4 prefix parser: classifier, token queue, parser.
// ----------------------------------------------------------------------------
module ipv4_cidr_text_parser_core import icp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_text_char,
  input  logic        in_is_terminator,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_status,
  output logic [31:0] out_address,
  output logic [5:0]  out_prefix_length
);

  token_t  front_tok, back_tok;
  logic    tok_empty, tok_rd;
  result_t res;

  // Classify characters
  icp_front u_front (
    .text_char     (in_text_char),
    .is_terminator (in_is_terminator),
    .tok           (front_tok)
  );

  // Token queue
  icp_tok_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (in_push),
    .wr_tok (front_tok),
    .full   (in_full),
    .rd     (tok_rd),
    .rd_tok (back_tok),
    .empty  (tok_empty)
  );

  // Parser and result buffer
  icp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok       (back_tok),
    .tok_empty (tok_empty),
    .tok_rd    (tok_rd),
    .res       (res),
    .res_empty (out_empty),
    .res_pop   (out_pop)
  );

  assign out_status        = res.status;
  assign out_address       = res.address;
  assign out_prefix_length = res.prefix_length;

endmodule

@@ rtl/core/icp_checker.sv @@
// ----------------------------------------------------------------------------
// icp_checker
// Port-level checks on the parser results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module icp_checker import icp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_address,
  input  logic [5:0]  out_prefix_length
);

  // Only defined status codes leave the block
  `ASSERT_CLK(a_status_code, clk, rst_n, !out_empty |-> (out_status == ST_OK || out_status == ST_BAD_ADDR || out_status == ST_BAD_LEN), "undefined status code")

  // Error results carry zero address and length
  `ASSERT_CLK(a_err_zero, clk, rst_n, (!out_empty && out_status != ST_OK) |-> (out_address == '0 && out_prefix_length == '0), "error result not zeroed")

  // A valid prefix never exceeds 32 bits
  `ASSERT_CLK(a_len_range, clk, rst_n, (!out_empty && out_status == ST_OK) |-> (out_prefix_length <= LENGTH_MAX), "prefix length above 32")

  // A waiting result holds until popped
  `ASSERT_CLK(a_hold, clk, rst_n, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_status) && $stable(out_address) && $stable(out_prefix_length)), "waiting result changed")

endmodule

bind ipv4_cidr_text_parser_core icp_checker u_icp_checker (.*);
